FILE: rtl/mbe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time block.
package mbe_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 60;
  localparam int COUNT_BITS_DEF = 16;

  // Entries in the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // Fixed field widths
  localparam int Z_W       = 64;
  localparam int STEP_W    = 63;
  localparam int COORD_W   = 10;
  localparam int DIM_W     = 11;
  localparam int CNT_W     = 16;
  localparam int ADDR_W    = 20;
  localparam int WIDE_W    = 128;
  localparam int PROD_W    = STEP_W + COORD_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  // Register reset values
  localparam logic signed [Z_W-1:0]  ORIGIN_RE_RST = 64'shE000_0000_0000_0000; // -2.0
  localparam logic signed [Z_W-1:0]  ORIGIN_IM_RST = 64'shF000_0000_0000_0000; // -1.0
  localparam logic [STEP_W-1:0]      STEP_RE_RST   = 63'h000C_0000_0000_0000;  // 3/1024
  localparam logic [STEP_W-1:0]      STEP_IM_RST   = 63'h0008_0000_0000_0000;  // 2/1024
  localparam logic [CNT_W-1:0]       LIMIT_RST     = 16'd100;
  localparam logic [DIM_W-1:0]       WIDTH_RST     = 11'd1024;
  localparam logic [DIM_W-1:0]       HEIGHT_RST    = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_RE,
    REG_ORIGIN_IM,
    REG_STEP_RE,
    REG_STEP_IM,
    REG_ITERATION_LIMIT,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic signed [Z_W-1:0] origin_re;
    logic signed [Z_W-1:0] origin_im;
    logic [STEP_W-1:0]     step_re;
    logic [STEP_W-1:0]     step_im;
    logic [CNT_W-1:0]      iteration_limit;
    logic [DIM_W-1:0]      image_width;
    logic [DIM_W-1:0]      image_height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
    logic signed [Z_W-1:0] start_z_re;
    logic signed [Z_W-1:0] start_z_im;
  } pixel_in_t;

  typedef struct packed {
    logic [COORD_W-1:0]    column_out;
    logic [COORD_W-1:0]    row_out;
    logic [ADDR_W-1:0]     pixel_address;
    logic                  escaped;
    logic [CNT_W-1:0]      iteration_count;
    logic signed [Z_W-1:0] final_z_re;
    logic signed [Z_W-1:0] final_z_im;
  } result_t;

  // One classified pixel, front end to back end
  typedef struct packed {
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
    logic [ADDR_W-1:0]     pixel_address;
    logic signed [Z_W-1:0] z_re;
    logic signed [Z_W-1:0] z_im;
    logic signed [Z_W-1:0] c_re;
    logic signed [Z_W-1:0] c_im;
  } work_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_t;

  // Steps of one z update on the shared multiplier array
  typedef enum logic [2:0] {
    PH_OPERAND,
    PH_MUL_RR,
    PH_MUL_II,
    PH_MUL_RI,
    PH_SUMS,
    PH_UPDATE_RE,
    PH_UPDATE_IM
  } phase_t;

  // Clamp a wide signed value to the signed 64-bit range
  function automatic logic signed [Z_W-1:0] sat64(input logic signed [WIDE_W-1:0] x);
    logic fits;
    fits = (&x[WIDE_W-1:Z_W-1]) || !(|x[WIDE_W-1:Z_W-1]);
    if (fits) begin
      sat64 = x[Z_W-1:0];
    end else if (x[WIDE_W-1]) begin
      sat64 = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      sat64 = {1'b0, {(Z_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: rtl/mbe_front.sv
// Front end: takes pixels, forms c and the row-flipped address, feeds the queue.
module mbe_front import mbe_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  pixel_in_t in_data,
  output logic      push,
  output work_t     push_data,
  input  logic      full
);

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int DW = (WB > DIM_W) ? WB : DIM_W;
  localparam int DH = (HB > DIM_W) ? HB : DIM_W;

  // stage A: raw pixel
  logic      a_valid;
  pixel_in_t a_data;
  // stage B: products
  logic                  b_valid;
  logic [COORD_W-1:0]    b_col;
  logic [COORD_W-1:0]    b_row;
  logic signed [Z_W-1:0] b_zr;
  logic signed [Z_W-1:0] b_zi;
  logic [PROD_W-1:0]     b_prod_re;
  logic [PROD_W-1:0]     b_prod_im;
  logic [ADDR_W-1:0]     b_addr_prod;

  logic a_move, b_move, accept;
  logic [DW-1:0]     w_eff;
  logic [DH-1:0]     h_eff;
  logic [ADDR_W-1:0] flip_row;
  logic signed [WIDE_W-1:0] c_re_wide, c_im_wide;

  assign b_move   = b_valid && !full;
  assign a_move   = a_valid && (!b_valid || b_move);
  assign in_stall = a_valid && b_valid && !b_move;
  assign accept   = in_valid && !in_stall;
  assign push     = b_move;

  // oversized image registers fall back to the maximum
  assign w_eff = (DW'(cfg.image_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH)
                                                          : DW'(cfg.image_width);
  assign h_eff = (DH'(cfg.image_height) > DH'(MAX_HEIGHT)) ? DH'(MAX_HEIGHT)
                                                            : DH'(cfg.image_height);
  assign flip_row = ADDR_W'(h_eff) - ADDR_W'(1) - ADDR_W'(a_data.row);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        b_valid <= 1'b1;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_data <= in_data;
    end
    if (a_move) begin
      b_col       <= a_data.column;
      b_row       <= a_data.row;
      b_zr        <= a_data.start_z_re;
      b_zi        <= a_data.start_z_im;
      b_prod_re   <= PROD_W'(cfg.step_re) * PROD_W'(a_data.column);
      b_prod_im   <= PROD_W'(cfg.step_im) * PROD_W'(a_data.row);
      b_addr_prod <= ADDR_W'(flip_row * ADDR_W'(w_eff));
    end
  end

  assign c_re_wide = $signed({{(WIDE_W-Z_W){cfg.origin_re[Z_W-1]}}, cfg.origin_re})
                   + $signed({{(WIDE_W-PROD_W){1'b0}}, b_prod_re});
  assign c_im_wide = $signed({{(WIDE_W-Z_W){cfg.origin_im[Z_W-1]}}, cfg.origin_im})
                   + $signed({{(WIDE_W-PROD_W){1'b0}}, b_prod_im});

  always_comb begin
    push_data.column        = b_col;
    push_data.row           = b_row;
    push_data.pixel_address = b_addr_prod + ADDR_W'(b_col);
    push_data.z_re          = b_zr;
    push_data.z_im          = b_zi;
    push_data.c_re          = sat64(c_re_wide);
    push_data.c_im          = sat64(c_im_wide);
  end

endmodule

FILE: rtl/mbe_queue.sv
// Small FIFO of classified pixels between front and back end.
module mbe_queue import mbe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output work_t head
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  work_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign full       = (fill == FILL_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

endmodule

FILE: rtl/mbe_back.sv
// Back end: iterates z = z*z + c on a shared 64x64 multiplier, holds the result.
module mbe_back import mbe_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    head_valid,
  input  work_t   head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  // |z|^2 > 4 in Q(2F) units
  localparam logic [WIDE_W-1:0] THRESH = WIDE_W'(1) << (2 * FRAC_BITS + 2);

  back_state_t state, state_next;
  phase_t      phase, phase_next;

  logic signed [Z_W-1:0] zr, zi, cr, ci;
  logic [COORD_W-1:0]    col, row;
  logic [ADDR_W-1:0]     addr;
  logic [COUNT_BITS-1:0] n;
  logic [COUNT_BITS-1:0] limit;

  logic [Z_W-1:0]    op_a, op_b;
  logic [Z_W-1:0]    p00, p01, p10, p11;
  logic [WIDE_W-1:0] rr, ii, ri_mag, prod;
  logic signed [WIDE_W-1:0] diff, ri;
  logic signed [WIDE_W-1:0] re_wide, im_wide;
  logic hit, res_escaped, esc_now, finish, out_load;

  function automatic logic [Z_W-1:0] mag(input logic signed [Z_W-1:0] v);
    mag = v[Z_W-1] ? Z_W'(-v) : Z_W'(v);
  endfunction

  assign limit   = cfg.iteration_limit[COUNT_BITS-1:0];
  assign esc_now = hit && (n != '0);
  assign finish  = esc_now || (n == limit);

  // reassemble the four 32x32 partials
  assign prod = {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};

  assign re_wide = (diff >>> FRAC_BITS) + $signed({{(WIDE_W-Z_W){cr[Z_W-1]}}, cr});
  assign im_wide = (ri >>> (FRAC_BITS - 1)) + $signed({{(WIDE_W-Z_W){ci[Z_W-1]}}, ci});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      phase <= PH_OPERAND;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          state_next = BK_RUN;
          phase_next = PH_OPERAND;
        end
      end
      BK_RUN: begin
        unique case (phase)
          PH_OPERAND:   phase_next = PH_MUL_RR;
          PH_MUL_RR:    phase_next = PH_MUL_II;
          PH_MUL_II:    phase_next = PH_MUL_RI;
          PH_MUL_RI:    phase_next = PH_SUMS;
          PH_SUMS:      phase_next = PH_UPDATE_RE;
          PH_UPDATE_RE: begin
            if (finish) begin
              state_next = BK_DONE;
            end else begin
              phase_next = PH_UPDATE_IM;
            end
          end
          PH_UPDATE_IM: phase_next = PH_MUL_RR;
          default:      phase_next = PH_OPERAND;
        endcase
      end
      BK_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // partials are taken every cycle from whatever operands are staged
  always_ff @(posedge clk) begin
    p00 <= Z_W'(op_a[31:0])  * Z_W'(op_b[31:0]);
    p01 <= Z_W'(op_a[31:0])  * Z_W'(op_b[63:32]);
    p10 <= Z_W'(op_a[63:32]) * Z_W'(op_b[31:0]);
    p11 <= Z_W'(op_a[63:32]) * Z_W'(op_b[63:32]);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      zr   <= head.z_re;
      zi   <= head.z_im;
      cr   <= head.c_re;
      ci   <= head.c_im;
      col  <= head.column;
      row  <= head.row;
      addr <= head.pixel_address;
      n    <= '0;
    end
    if (state == BK_RUN) begin
      unique case (phase)
        PH_OPERAND: begin
          op_a <= mag(zr);
          op_b <= mag(zr);
        end
        PH_MUL_RR: begin
          op_a <= mag(zi);
          op_b <= mag(zi);
        end
        PH_MUL_II: begin
          rr   <= prod;
          op_a <= mag(zr);
          op_b <= mag(zi);
        end
        PH_MUL_RI: begin
          ii <= prod;
        end
        PH_SUMS: begin
          ri_mag <= prod;
          hit    <= (rr + ii) > THRESH;  // escape test on the last update
          diff   <= $signed(rr - ii);
        end
        PH_UPDATE_RE: begin
          res_escaped <= esc_now;
          if (!finish) begin
            ri <= (zr[Z_W-1] ^ zi[Z_W-1]) ? -$signed(ri_mag) : $signed(ri_mag);
            zr <= sat64(re_wide);
          end
        end
        PH_UPDATE_IM: begin
          zi   <= sat64(im_wide);
          n    <= n + COUNT_BITS'(1);
          op_a <= mag(zr);
          op_b <= mag(zr);
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.column_out      <= col;
      out_data.row_out         <= row;
      out_data.pixel_address   <= addr;
      out_data.escaped         <= res_escaped;
      out_data.iteration_count <= CNT_W'(res_escaped ? n - COUNT_BITS'(1) : n);
      out_data.final_z_re      <= zr;
      out_data.final_z_im      <= zi;
    end
  end

  a_loop_back: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN && phase == PH_UPDATE_IM) |=> (state == BK_RUN && phase == PH_MUL_RR))
    else $error("update did not start a new product sequence");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (n <= limit))
    else $error("update count ran past the limit");

  a_limit_result: assert property (@(posedge clk) disable iff (rst)
    (out_load && !res_escaped) |-> (n == limit))
    else $error("unescaped pixel finished before the limit");

endmodule

FILE: rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time unit: config registers, front, queue, back.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   in_data  (pixel_in_t: column, row, start z)
//   out      out  out_valid/out_stall out_data (result_t: address, escaped, count, z)
//   cfg      in   cfg_write           cfg_index, cfg_data (no read-back)
//
// The back end works on one pixel at a time; each z update takes three products
//   (re^2, im^2, re*im) from the four 32x32 multipliers, which form one 64x64 product
//   per cycle.
// The front end takes a pixel every cycle while the queue has room, so the next pixels
//   are classified while the back end iterates.
// Reset (rst, synchronous) empties the pipe and loads the default view registers.
// A stalled output holds the back end in its done state; the queue then fills and
//   in_stall rises.
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pixel_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_data
);

  cfg_t  cfg;
  logic  push, full, pop, head_valid;
  work_t push_data, head;

  // view registers; the user must write them only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_re       <= ORIGIN_RE_RST;
      cfg.origin_im       <= ORIGIN_IM_RST;
      cfg.step_re         <= STEP_RE_RST;
      cfg.step_im         <= STEP_IM_RST;
      cfg.iteration_limit <= LIMIT_RST;
      cfg.image_width     <= WIDTH_RST;
      cfg.image_height    <= HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_RE:       cfg.origin_re       <= cfg_data;
        REG_ORIGIN_IM:       cfg.origin_im       <= cfg_data;
        REG_STEP_RE:         cfg.step_re         <= cfg_data[STEP_W-1:0];
        REG_STEP_IM:         cfg.step_im         <= cfg_data[STEP_W-1:0];
        REG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[CNT_W-1:0];
        REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[DIM_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front: c = origin + step * (column, row), flipped address
  mbe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // decouples classification from the long iteration
  mbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: escape-time loop and output register
  mbe_back #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
